[design/csav_pkg.sv]
`timescale 1ns / 1ps

package csav_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int SUM_W   = 66;
  localparam int LEN_W   = 33;

  localparam logic FUNC_MOVE = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

endpackage

[design/csav_in_if.sv]
`timescale 1ns / 1ps

interface csav_in_if import csav_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   func;
  coord_t step_distance;
  coord_t load_eye_x;
  coord_t load_eye_y;
  coord_t load_eye_z;
  coord_t load_target_x;
  coord_t load_target_y;
  coord_t load_target_z;

  modport source (
    output valid, func, step_distance, load_eye_x, load_eye_y, load_eye_z,
           load_target_x, load_target_y, load_target_z,
    input  ready
  );
  modport sink (
    input  valid, func, step_distance, load_eye_x, load_eye_y, load_eye_z,
           load_target_x, load_target_y, load_target_z,
    output ready
  );
endinterface

[design/csav_out_if.sv]
`timescale 1ns / 1ps

interface csav_out_if import csav_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t eye_x;
  coord_t eye_y;
  coord_t eye_z;
  coord_t target_x;
  coord_t target_y;
  coord_t target_z;
  logic   degenerate;

  modport source (
    output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, degenerate,
    output ready
  );
endinterface

[design/camera_step_along_view_top.sv]
`timescale 1ns / 1ps

// Camera that steps its eye and target points along the view direction.
// Input channel in_ch: one item per command. func selects load (write both
// points) or move (advance both points by step_distance along the unit
// vector from eye to target). Output channel out_ch: exactly one item per
// input item, carrying both points after the command and a degenerate flag
// (set when a move found eye == target; points then unchanged).
// Coordinates are signed fixed point with FRAC_BITS fraction bits.
// A load goes from its accept through ST_OUT into the output register. A
// move runs bit-serially: a difference step, the squared length summed
// over the three axes on a serial multiplier, the square root, then per axis
// a divide, a multiply, a rounding and an update step, and last ST_OUT.
// One item is in work at a time; in_ch.ready is high only when idle.
// The result sits in an output register; a stalled receiver holds the block
// at its final step, and the next item can be taken before it is drained.
// Reset (rst_n low, synchronous) zeroes both points and empties the output.
module camera_step_along_view_top import csav_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  csav_in_if.sink    in_ch,
  csav_out_if.source out_ch
);
  localparam int QW = FRAC_BITS + 1;
  localparam int PW = QW + 32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_SQ_GO, ST_SQ_WAIT, ST_CHK, ST_SQRT,
    ST_DV_GO, ST_DV_WAIT, ST_ML_WAIT, ST_RND, ST_UPD, ST_OUT
  } state_t;

  state_t           state_r;
  coord_t           eye_r [3];
  coord_t           tgt_r [3];
  diff_t            d_r   [3];
  logic [1:0]       ax_r;
  coord_t           step_r;
  logic [SUM_W-1:0] sum_r;
  logic [LEN_W-1:0] len_r;
  logic [32:0]      pm_r;
  logic             degen_r;
  logic             out_valid_r;
  coord_t           out_eye_r [3];
  coord_t           out_tgt_r [3];
  logic             out_degen_r;

  // serial unit hookup
  logic             sq_start, sq_done;
  logic [63:0]      sq_p;
  logic             rt_start, rt_done;
  logic [LEN_W-1:0] rt_root;
  logic             dv_start, dv_done;
  logic [QW-1:0]    dv_q;
  logic             ml_start, ml_done;
  logic [PW-1:0]    ml_p;
  logic [31:0]      d_mag;
  logic [31:0]      step_mag;
  logic             in_acc;
  logic             out_free;

  function automatic logic [31:0] mag33(input diff_t v);
    diff_t n;
    n = -v;
    return v[DIFF_W-1] ? n[31:0] : v[31:0];
  endfunction

  // coordinate plus signed offset, clamped to the 32-bit range
  function automatic coord_t add_sat(input coord_t c, input logic [32:0] pm,
                                     input logic neg);
    logic signed [34:0] s;
    logic signed [34:0] off;
    off = neg ? -$signed({2'b00, pm}) : $signed({2'b00, pm});
    s   = 35'(c) + off;
    if (s > 35'sd2147483647) return 32'sh7FFFFFFF;
    else if (s < -35'sd2147483648) return 32'sh80000000;
    else return s[31:0];
  endfunction

  assign d_mag    = mag33(d_r[ax_r]);
  assign step_mag = step_r[31] ? 32'(-step_r) : 32'(step_r);

  assign sq_start = (state_r == ST_SQ_GO);
  assign rt_start = (state_r == ST_CHK) && (sum_r != '0);
  assign dv_start = (state_r == ST_DV_GO);
  assign ml_start = (state_r == ST_DV_WAIT) && dv_done;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  csav_smul #(.WA(32), .WB(32)) u_sq (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .a(d_mag), .b(d_mag), .done(sq_done), .p(sq_p)
  );

  csav_isqrt u_rt (
    .clk(clk), .rst_n(rst_n), .start(rt_start),
    .val(sum_r), .done(rt_done), .root(rt_root)
  );

  csav_sdiv #(.FRAC_BITS(FRAC_BITS)) u_dv (
    .clk(clk), .rst_n(rst_n), .start(dv_start),
    .m(d_mag), .len(len_r), .done(dv_done), .q(dv_q)
  );

  csav_smul #(.WA(32), .WB(QW)) u_ml (
    .clk(clk), .rst_n(rst_n), .start(ml_start),
    .a(step_mag), .b(dv_q), .done(ml_done), .p(ml_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ax_r        <= '0;
      for (int i = 0; i < 3; i++) begin
        eye_r[i] <= '0;
        tgt_r[i] <= '0;
      end
    end else begin
      // ST_OUT reloads the output register itself when it is drained
      if (out_valid_r && out_ch.ready && state_r != ST_OUT) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_ch.func == FUNC_LOAD) begin
              eye_r[0] <= in_ch.load_eye_x;
              eye_r[1] <= in_ch.load_eye_y;
              eye_r[2] <= in_ch.load_eye_z;
              tgt_r[0] <= in_ch.load_target_x;
              tgt_r[1] <= in_ch.load_target_y;
              tgt_r[2] <= in_ch.load_target_z;
              degen_r  <= 1'b0;
              state_r  <= ST_OUT;
            end else begin
              step_r  <= in_ch.step_distance;
              state_r <= ST_DIFF;
            end
          end
        end
        ST_DIFF: begin
          for (int i = 0; i < 3; i++) d_r[i] <= diff_t'(tgt_r[i]) - diff_t'(eye_r[i]);
          sum_r   <= '0;
          ax_r    <= '0;
          state_r <= ST_SQ_GO;
        end
        ST_SQ_GO: state_r <= ST_SQ_WAIT;
        ST_SQ_WAIT: begin
          if (sq_done) begin
            sum_r <= sum_r + SUM_W'(sq_p);
            if (ax_r == 2'd2) begin
              state_r <= ST_CHK;
            end else begin
              ax_r    <= ax_r + 1'b1;
              state_r <= ST_SQ_GO;
            end
          end
        end
        ST_CHK: begin
          if (sum_r == '0) begin
            degen_r <= 1'b1;
            state_r <= ST_OUT;
          end else begin
            degen_r <= 1'b0;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (rt_done) begin
            len_r   <= rt_root;
            ax_r    <= '0;
            state_r <= ST_DV_GO;
          end
        end
        ST_DV_GO: state_r <= ST_DV_WAIT;
        ST_DV_WAIT: begin
          if (dv_done) state_r <= ST_ML_WAIT;
        end
        ST_ML_WAIT: begin
          if (ml_done) state_r <= ST_RND;
        end
        ST_RND: begin
          // round half away from zero on the magnitude
          pm_r    <= 33'((ml_p + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          eye_r[ax_r] <= add_sat(eye_r[ax_r], pm_r, d_r[ax_r][DIFF_W-1] ^ step_r[31]);
          tgt_r[ax_r] <= add_sat(tgt_r[ax_r], pm_r, d_r[ax_r][DIFF_W-1] ^ step_r[31]);
          if (ax_r == 2'd2) begin
            state_r <= ST_OUT;
          end else begin
            ax_r    <= ax_r + 1'b1;
            state_r <= ST_DV_GO;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              out_eye_r[i] <= eye_r[i];
              out_tgt_r[i] <= tgt_r[i];
            end
            out_degen_r <= degen_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.eye_x      = out_eye_r[0];
  assign out_ch.eye_y      = out_eye_r[1];
  assign out_ch.eye_z      = out_eye_r[2];
  assign out_ch.target_x   = out_tgt_r[0];
  assign out_ch.target_y   = out_tgt_r[1];
  assign out_ch.target_z   = out_tgt_r[2];
  assign out_ch.degenerate = out_degen_r;
endmodule

[design/csav_smul.sv]
`timescale 1ns / 1ps

// Bit-serial unsigned multiplier, one bit of b per cycle, MSB first.
module csav_smul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic             done,
  output logic [WA+WB-1:0] p
);
  localparam int CW = $clog2(WB + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [WA-1:0]    a_r;
  logic [WB-1:0]    b_r;
  logic [WA+WB-1:0] p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      p_r <= '0;
    end else if (busy_r) begin
      p_r <= (p_r << 1) + (b_r[WB-1] ? {{WB{1'b0}}, a_r} : '0);
      b_r <= b_r << 1;
    end
  end

  assign done = done_r;
  assign p    = p_r;
endmodule

[design/csav_isqrt.sv]
`timescale 1ns / 1ps

// Digit-by-digit integer square root, one bit pair per cycle.
module csav_isqrt import csav_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] val,
  output logic             done,
  output logic [LEN_W-1:0] root
);
  localparam int RW = LEN_W + 3;   // remainder after shifting in a pair
  localparam int CW = $clog2(LEN_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [SUM_W-1:0] val_r;
  logic [RW-3:0]    rem_r;
  logic [LEN_W-1:0] root_r;
  logic [RW-1:0]    rem_sh;
  logic [RW-1:0]    trial;
  logic             take;

  assign rem_sh = {rem_r, val_r[SUM_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(LEN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= val;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= val_r << 2;
      rem_r  <= take ? (RW-2)'(rem_sh - trial) : (RW-2)'(rem_sh);
      root_r <= {root_r[LEN_W-2:0], take};
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

[design/csav_sdiv.sv]
`timescale 1ns / 1ps

// Restoring divider for (m << FRAC_BITS) / len, with len >= m so the
// quotient fits FRAC_BITS+1 bits. One quotient bit per cycle.
module csav_sdiv import csav_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        m,
  input  logic [LEN_W-1:0]   len,
  output logic               done,
  output logic [FRAC_BITS:0] q
);
  localparam int QW = FRAC_BITS + 1;
  localparam int CW = $clog2(QW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [LEN_W-1:0] rem_r;
  logic [LEN_W-1:0] len_r;
  logic [QW-1:0]    ds_r;
  logic [QW-1:0]    q_r;
  logic [LEN_W:0]   r2;
  logic             take;

  assign r2   = {rem_r, ds_r[QW-1]};
  assign take = (r2 >= {1'b0, len_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // upper dividend bits (m >> 1) are below len, so start there
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {2'b00, m[31:1]};
      len_r <= len;
      ds_r  <= {m[0], {FRAC_BITS{1'b0}}};
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= take ? LEN_W'(r2 - {1'b0, len_r}) : LEN_W'(r2);
      ds_r  <= ds_r << 1;
      q_r   <= {q_r[QW-2:0], take};
    end
  end

  assign done = done_r;
  assign q    = q_r;
endmodule

[design/csav_checker.sv]
`timescale 1ns / 1ps

module csav_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_eye_x,
  input logic out_degenerate
);
  // result held while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_eye_x) && $stable(out_degenerate))
    else $error("out item changed under stall");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // a result never shows up the cycle right after an accept
  a_no_shortcut: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too early");
endmodule

bind camera_step_along_view_top csav_checker u_csav_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_eye_x(out_ch.eye_x),
  .out_degenerate(out_ch.degenerate)
);

[dv/tb_camera_step_along_view_top.sv]
`timescale 1ns / 1ps

module tb_camera_step_along_view_top;
  import csav_pkg::*;

  localparam int FB        = 16;
  localparam int NUM_RAND  = 2000;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic   func;
    coord_t step;
    coord_t ex, ey, ez, tx, ty, tz;
  } cam_cmd_t;

  typedef struct packed {
    coord_t ex, ey, ez, tx, ty, tz;
    logic   degen;
  } cam_view_t;

  // Tracks camera state and the queue of views the block owes us.
  class camera_scoreboard;
    longint eye[3];
    longint tgt[3];
    cam_view_t pending_views[$];
    int errors;

    function new();
      errors = 0;
      for (int i = 0; i < 3; i++) begin
        eye[i] = 0;
        tgt[i] = 0;
      end
    endfunction

    static function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Bit-by-bit floor square root of a 66-bit value.
    static function logic [32:0] root66(logic [65:0] v);
      logic [67:0] rem;
      logic [67:0] trial;
      logic [32:0] root;
      rem = '0;
      root = '0;
      for (int k = 32; k >= 0; k--) begin
        rem = (rem << 2) | v[2*k +: 2];
        trial = {root, 2'b01};
        if (rem >= trial) begin
          rem = rem - trial;
          root = {root[31:0], 1'b1};
        end else begin
          root = {root[31:0], 1'b0};
        end
      end
      return root;
    endfunction

    function bit advance(coord_t step);
      longint d[3];
      logic [65:0] sq;
      logic [32:0] len;
      logic [32:0] dm;
      logic [127:0] um, pm;
      logic [31:0] sm;
      longint off;
      sq = '0;
      for (int i = 0; i < 3; i++) begin
        d[i] = tgt[i] - eye[i];
        dm = 33'((d[i] < 0) ? -d[i] : d[i]);
        sq = sq + 66'(dm) * 66'(dm);
      end
      if (sq == 0) return 1'b1;
      len = root66(sq);
      sm = 32'((step < 0) ? -longint'(step) : longint'(step));
      for (int i = 0; i < 3; i++) begin
        dm = 33'((d[i] < 0) ? -d[i] : d[i]);
        um = (128'(dm) << FB) / 128'(len);
        pm = (um * 128'(sm) + (128'd1 << (FB - 1))) >> FB;
        off = ((d[i] < 0) != (step < 0)) ? -longint'(pm[63:0]) : longint'(pm[63:0]);
        eye[i] = clamp32(eye[i] + off);
        tgt[i] = clamp32(tgt[i] + off);
      end
      return 1'b0;
    endfunction

    function void note_cmd(cam_cmd_t c);
      cam_view_t v;
      logic dg;
      dg = 1'b0;
      if (c.func == FUNC_LOAD) begin
        eye[0] = c.ex; eye[1] = c.ey; eye[2] = c.ez;
        tgt[0] = c.tx; tgt[1] = c.ty; tgt[2] = c.tz;
      end else begin
        dg = advance(c.step);
      end
      v.ex = coord_t'(eye[0]); v.ey = coord_t'(eye[1]); v.ez = coord_t'(eye[2]);
      v.tx = coord_t'(tgt[0]); v.ty = coord_t'(tgt[1]); v.tz = coord_t'(tgt[2]);
      v.degen = dg;
      pending_views.push_back(v);
    endfunction

    function void check_view(cam_view_t a);
      cam_view_t e;
      if (pending_views.size() == 0) begin
        $error("unexpected output item");
        errors++;
        return;
      end
      e = pending_views.pop_front();
      if (a.ex !== e.ex) begin $error("eye_x exp %0d got %0d", e.ex, a.ex); errors++; end
      if (a.ey !== e.ey) begin $error("eye_y exp %0d got %0d", e.ey, a.ey); errors++; end
      if (a.ez !== e.ez) begin $error("eye_z exp %0d got %0d", e.ez, a.ez); errors++; end
      if (a.tx !== e.tx) begin
        $error("target_x exp %0d got %0d", e.tx, a.tx); errors++;
      end
      if (a.ty !== e.ty) begin
        $error("target_y exp %0d got %0d", e.ty, a.ty); errors++;
      end
      if (a.tz !== e.tz) begin
        $error("target_z exp %0d got %0d", e.tz, a.tz); errors++;
      end
      if (a.degen !== e.degen) begin
        $error("degenerate exp %0b got %0b", e.degen, a.degen); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  csav_in_if  in_ch ();
  csav_out_if out_ch ();

  camera_step_along_view_top #(.FRAC_BITS(FB)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  camera_scoreboard sb;
  cam_cmd_t cmd_q[$];
  bit  stim_done;
  bit  long_hold;     // receiver hold-off request, set by the sender side
  int  idle_cycles;

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return coord_t'($urandom_range(0, 200) - 100) <<< 16;
      3: return coord_t'($urandom_range(0, 20000)) - 10000;
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic cam_cmd_t mk_load(coord_t ex, ey, ez, tx, ty, tz);
    cam_cmd_t c;
    c.func = FUNC_LOAD;
    c.step = coord_t'($urandom());
    c.ex = ex; c.ey = ey; c.ez = ez; c.tx = tx; c.ty = ty; c.tz = tz;
    return c;
  endfunction

  function automatic cam_cmd_t mk_move(coord_t s);
    cam_cmd_t c;
    c = cam_cmd_t'({1'b0, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom()});
    c.func = FUNC_MOVE;
    c.step = s;
    return c;
  endfunction

  // Directed opening: extremes, both funcs, degenerate and saturation cases.
  task automatic build_directed();
    cmd_q.push_back(mk_move(32'sh00010000));               // eye == target after reset
    cmd_q.push_back(mk_load(0, 0, 0, 32'sh00010000, 0, 0));
    cmd_q.push_back(mk_move(32'sh00020000));
    cmd_q.push_back(mk_move(-32'sh00008000));
    cmd_q.push_back(mk_move(32'sh7fffffff));                // saturates
    cmd_q.push_back(mk_move(32'sh80000000));
    cmd_q.push_back(mk_load(32'sh80000000, 32'sh80000000, 32'sh80000000,
                            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    cmd_q.push_back(mk_move(32'sh00010000));
    cmd_q.push_back(mk_move(32'sh80000000));
    cmd_q.push_back(mk_load(32'sh7fffffff, 32'sh80000000, 0,
                            32'sh80000000, 32'sh7fffffff, 32'sh7fffffff));
    cmd_q.push_back(mk_move(32'sh7fffffff));
    cmd_q.push_back(mk_move(0));
    cmd_q.push_back(mk_load(5, -7, 3, 5, -7, 3));            // degenerate load
    cmd_q.push_back(mk_move(-32'sh00030000));
    cmd_q.push_back(mk_load(0, 0, 0, 1, 1, 1));               // tiny direction
    cmd_q.push_back(mk_move(32'sh00000001));
    cmd_q.push_back(mk_move(-1));
    cmd_q.push_back(mk_load(32'shffffffff, 32'shffffffff, 32'shffffffff,
                            32'shffffffff, 32'shffffffff, 32'shffffffff));
    cmd_q.push_back(mk_move(32'shffffffff));
  endtask

  task automatic build_random();
    coord_t s;
    for (int n = 0; n < NUM_RAND; n++) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          s = rand_coord();
          cmd_q.push_back(mk_load(s, s, s, s, s, s));
        end else begin
          cmd_q.push_back(mk_load(rand_coord(), rand_coord(), rand_coord(),
                                  rand_coord(), rand_coord(), rand_coord()));
        end
      end else begin
        cmd_q.push_back(mk_move($urandom_range(0, 3) == 0 ? coord_t'($urandom())
                                : rand_coord()));
      end
    end
  endtask

  task automatic send_cmd(cam_cmd_t c);
    in_ch.valid         <= 1'b1;
    in_ch.func          <= c.func;
    in_ch.step_distance <= c.step;
    in_ch.load_eye_x    <= c.ex;
    in_ch.load_eye_y    <= c.ey;
    in_ch.load_eye_z    <= c.ez;
    in_ch.load_target_x <= c.tx;
    in_ch.load_target_y <= c.ty;
    in_ch.load_target_z <= c.tz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_cmd(c);
  endtask

  // Sender: keeps valid high across back-to-back items, drops it for gaps.
  initial begin
    int gap;
    cam_cmd_t c;
    sb = new();
    stim_done = 1'b0;
    long_hold = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_MOVE;
    in_ch.step_distance <= '0;
    in_ch.load_eye_x <= '0;
    in_ch.load_eye_y <= '0;
    in_ch.load_eye_z <= '0;
    in_ch.load_target_x <= '0;
    in_ch.load_target_y <= '0;
    in_ch.load_target_z <= '0;
    build_directed();
    build_random();
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int n = 0; cmd_q.size() > 0; n++) begin
      c = cmd_q.pop_front();
      if (n == 40) long_hold = 1'b1;            // receiver stalls for a while
      // stretch with no gaps, else random gaps of 0..7
      gap = (n >= 300 && n < 500) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      send_cmd(c);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls per item, one long hold-off to back up the block.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (1500) @(posedge clk);
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      sb.check_view(cam_view_t'{out_ch.eye_x, out_ch.eye_y, out_ch.eye_z,
                                out_ch.target_x, out_ch.target_y, out_ch.target_z,
                                out_ch.degenerate});
    end
  end

  // Watchdog over cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge rst_n);
    fork
      begin
        wait (stim_done && sb.pending_views.size() == 0);
        repeat (300) @(posedge clk);
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("timeout waiting for a handshake");
        sb.errors++;
      end
    join_any
    if (sb.errors == 0 && sb.pending_views.size() == 0)
      $display("camera_step_along_view_top regression: pass");
    else
      $display("camera_step_along_view_top regression: fail");
    $finish;
  end

endmodule

[sim.f]
design/csav_pkg.sv
design/csav_in_if.sv
design/csav_out_if.sv
design/csav_smul.sv
design/csav_isqrt.sv
design/csav_sdiv.sv
design/camera_step_along_view_top.sv
design/csav_checker.sv
dv/tb_camera_step_along_view_top.sv
